/* src/srpc_pkg.sv */
// Shared types, character constants and rule-checker functions for the path checker.
`timescale 1ns / 1ps

package srpc_pkg;

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_PCT    = 8'h25;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        RSN_NONE     = 4'd0,
        RSN_EMPTY    = 4'd1,
        RSN_ABSOLUTE = 4'd2,
        RSN_DRIVE    = 4'd3,
        RSN_SCHEME   = 4'd4,
        RSN_NUL      = 4'd5,
        RSN_BSLASH   = 4'd6,
        RSN_DOT      = 4'd7,
        RSN_DOTDOT   = 4'd8
    } t_reason;

    typedef enum logic [1:0] {
        SCH_NONE  = 2'd0,
        SCH_CAND  = 2'd1,
        SCH_FOUND = 2'd2
    } t_scheme;

    typedef enum logic [1:0] {
        NB_NONE = 2'd0,
        NB_NUL  = 2'd1,
        NB_BSL  = 2'd2
    } t_nb;

    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } t_seg;

    typedef enum logic [1:0] {
        DOT_NONE = 2'd0,
        DOT_ONE  = 2'd1,
        DOT_TWO  = 2'd2
    } t_dot;

    // Flag state of one rule checker.
    typedef struct packed {
        logic [1:0] cnt;
        logic       absol;
        logic       drive;
        t_scheme    scheme;
        t_nb        nb;
        t_seg       seg;
        t_dot       dot;
    } t_chk;

    localparam t_chk CHK_CLEAR = '{cnt: 2'd0, absol: 1'b0, drive: 1'b0, scheme: SCH_NONE,
                                   nb: NB_NONE, seg: SEG_EMPTY, dot: DOT_NONE};

    typedef struct packed {
        logic [7:0] path_byte;
        logic       is_last;
        logic       path_empty;
    } t_in_word;

    typedef struct packed {
        logic       path_safe;
        logic [3:0] fail_reason;
        logic       failed_decoded;
    } t_out_word;

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_scheme_char(input logic [7:0] b);
        return is_alpha(b) || (b inside {[8'h30:8'h39], CHR_PLUS, CHR_MINUS, CHR_DOT});
    endfunction

    // Bit 4 is the valid flag, bits 3:0 the digit value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            v = {1'b1, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // A segment that ends as exactly "." or ".." is recorded once, first one wins.
    function automatic t_chk seg_close(input t_chk c);
        t_chk r;
        r = c;
        if (c.dot == DOT_NONE) begin
            if (c.seg == SEG_DOT) begin
                r.dot = DOT_ONE;
            end else if (c.seg == SEG_DOTDOT) begin
                r.dot = DOT_TWO;
            end
        end
        return r;
    endfunction

    function automatic t_chk chk_feed(input t_chk c, input logic [7:0] b);
        t_chk r;
        r = c;
        if (c.cnt == 2'd0) begin
            r.absol  = (b == CHR_SLASH);
            r.scheme = is_alpha(b) ? SCH_CAND : SCH_NONE;
        end else begin
            if (c.cnt == 2'd1 && c.scheme == SCH_CAND && b == CHR_COLON) begin
                r.drive = 1'b1;
            end
            if (c.scheme == SCH_CAND) begin
                if (b == CHR_COLON) begin
                    r.scheme = SCH_FOUND;
                end else if (!is_scheme_char(b)) begin
                    r.scheme = SCH_NONE;
                end
            end
        end
        if (c.nb == NB_NONE) begin
            if (b == CHR_NUL) begin
                r.nb = NB_NUL;
            end else if (b == CHR_BSLASH) begin
                r.nb = NB_BSL;
            end
        end
        if (b == CHR_SLASH) begin
            r.dot = seg_close(c).dot;
            r.seg = SEG_EMPTY;
        end else if (b == CHR_DOT) begin
            case (c.seg)
                SEG_EMPTY: r.seg = SEG_DOT;
                SEG_DOT:   r.seg = SEG_DOTDOT;
                default:   r.seg = SEG_OTHER;
            endcase
        end else begin
            r.seg = SEG_OTHER;
        end
        if (c.cnt != 2'd2) begin
            r.cnt = c.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic t_reason chk_result(input t_chk c);
        t_chk    f;
        t_reason r;
        f = seg_close(c);
        if (f.cnt == 2'd0) begin
            r = RSN_EMPTY;
        end else if (f.absol) begin
            r = RSN_ABSOLUTE;
        end else if (f.drive) begin
            r = RSN_DRIVE;
        end else if (f.scheme == SCH_FOUND) begin
            r = RSN_SCHEME;
        end else if (f.nb == NB_NUL) begin
            r = RSN_NUL;
        end else if (f.nb == NB_BSL) begin
            r = RSN_BSLASH;
        end else if (f.dot == DOT_ONE) begin
            r = RSN_DOT;
        end else if (f.dot == DOT_TWO) begin
            r = RSN_DOTDOT;
        end else begin
            r = RSN_NONE;
        end
        return r;
    endfunction

endpackage

/* src/safe_relative_path_checker.sv */
// Top level of the safe relative path checker with percent-decoded recheck.
`timescale 1ns / 1ps

// The block reads a path one byte per input word and, at the word that ends
// the path, returns one output word with the verdict: path_safe, a fail
// reason and whether the failure was only visible after %XX decoding.
// Both channels are valid/ready; a word moves when valid and ready are high
// at the same rising edge. An input word with path_empty set ends the path
// at once with reason "empty" and drops whatever bytes had come before.
// Words that are neither last nor empty produce no output word.
//
// The last byte sits in the input register while the core judges it, and
// the verdict is then registered in the result register behind o_out_valid.
// The block takes one byte per cycle unless a finished verdict cannot be
// placed; the per-byte work is the flag update of two small rule checkers
// and the two-byte decode window, with up to three decoded bytes pushed
// through the decoded checker at the end of a path.
//
// When the receiver stalls, the finished verdict waits in the result
// register while the next bytes are still taken; the input register fills
// only when a second verdict is ready and cannot be placed. Reset is
// synchronous and active low; it clears all checker state and empties both
// registers, so the next byte starts a new path.

module safe_relative_path_checker
    import srpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic      stg_valid;
    t_in_word  stg_data;
    logic      core_fire;
    logic      core_has_result;
    t_out_word core_result;
    logic      out_free;
    logic      r_out_valid;
    t_out_word r_out_data;

    srpc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (stg_valid),
        .i_take  (core_fire),
        .o_data  (stg_data)
    );

    srpc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (core_fire),
        .i_data       (stg_data),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    // A byte that yields no verdict never waits on the output side.
    assign out_free  = !r_out_valid || i_out_ready;
    assign core_fire = stg_valid && (!core_has_result || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= core_fire && core_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && core_fire && core_has_result) begin
            r_out_data <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/srpc_in_reg.sv */
// Input register stage holding one accepted word until the core consumes it.
`timescale 1ns / 1ps

module srpc_in_reg
    import srpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output logic     o_valid,
    input  logic     i_take,
    output t_in_word o_data
);

    logic     r_valid;
    t_in_word r_data;

    // The slot frees up in the same cycle the core takes its word.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

/* src/srpc_core.sv */
// Per-path state: raw checker, decode window and decoded checker, plus the verdict logic.
`timescale 1ns / 1ps

module srpc_core
    import srpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_data,
    output logic      o_has_result,
    output t_out_word o_result
);

    t_chk       r_raw;
    t_chk       r_dec;
    logic [7:0] r_w0;
    logic [7:0] r_w1;
    logic [1:0] r_wn;
    logic       r_seen;

    t_chk       n_raw;
    t_chk       n_dec;
    logic [7:0] n_w0;
    logic [7:0] n_w1;
    logic [1:0] n_wn;
    logic       n_seen;

    t_chk       dec_a;
    t_chk       dec_b;
    t_chk       dec_c;
    logic [4:0] hex_hi;
    logic [4:0] hex_lo;
    t_reason    rsn_raw;
    t_reason    rsn_dec;
    logic [7:0] b;

    assign b            = i_data.path_byte;
    assign o_has_result = i_data.path_empty || i_data.is_last;

    always_comb begin
        hex_hi = hex_val(r_w1);
        hex_lo = hex_val(b);
        n_raw  = chk_feed(r_raw, b);
        dec_a  = r_dec;
        n_w0   = r_w0;
        n_w1   = r_w1;
        n_wn   = r_wn;
        n_seen = r_seen;

        // Two-byte lookahead: a full window plus the new byte either forms an
        // escape, which is emitted as one byte, or the oldest byte leaves as is.
        case (r_wn)
            2'd2: begin
                if (r_w0 == CHR_PCT && hex_hi[4] && hex_lo[4]) begin
                    dec_a  = chk_feed(r_dec, {hex_hi[3:0], hex_lo[3:0]});
                    n_seen = 1'b1;
                    n_wn   = 2'd0;
                end else begin
                    dec_a = chk_feed(r_dec, r_w0);
                    n_w0  = r_w1;
                    n_w1  = b;
                end
            end
            2'd1: begin
                n_w1 = b;
                n_wn = 2'd2;
            end
            default: begin
                n_w0 = b;
                n_wn = 2'd1;
            end
        endcase
        n_dec = dec_a;

        // At the end of the path the pending bytes are flushed undecoded.
        dec_b   = (n_wn != 2'd0) ? chk_feed(dec_a, n_w0) : dec_a;
        dec_c   = (n_wn == 2'd2) ? chk_feed(dec_b, n_w1) : dec_b;
        rsn_raw = chk_result(n_raw);
        rsn_dec = chk_result(dec_c);

        if (i_data.path_empty) begin
            o_result.path_safe      = 1'b0;
            o_result.fail_reason    = RSN_EMPTY;
            o_result.failed_decoded = 1'b0;
        end else if (rsn_raw == RSN_NONE && n_seen && rsn_dec != RSN_NONE) begin
            o_result.path_safe      = 1'b0;
            o_result.fail_reason    = rsn_dec;
            o_result.failed_decoded = 1'b1;
        end else begin
            o_result.path_safe      = (rsn_raw == RSN_NONE);
            o_result.fail_reason    = rsn_raw;
            o_result.failed_decoded = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= CHK_CLEAR;
            r_dec  <= CHK_CLEAR;
            r_wn   <= 2'd0;
            r_seen <= 1'b0;
        end else if (i_fire) begin
            if (o_has_result) begin
                r_raw  <= CHK_CLEAR;
                r_dec  <= CHK_CLEAR;
                r_wn   <= 2'd0;
                r_seen <= 1'b0;
            end else begin
                r_raw  <= n_raw;
                r_dec  <= n_dec;
                r_wn   <= n_wn;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_w0 <= n_w0;
            r_w1 <= n_w1;
        end
    end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the safe relative path checker.
`timescale 1ns / 1ps

// The testbench sends paths to the checker one byte per input word. It
// predicts each verdict as the word is accepted and compares every output
// word with the oldest verdict still due.
//
// The verdict predictor keeps two rule checkers. One sees the raw bytes.
// The other sees the %XX-decoded bytes that come out of a two-byte window.
// At the end of a path the bytes still held in the window go through
// undecoded.
//
// Stimulus comes in two parts. A short directed list covers every fail
// reason, the byte extremes, an empty mark with and without a last mark,
// an empty mark that cuts a path short, a decoded-only failure and a
// window tail. After it come random paths. Most are built from pieces such
// as dot segments, slashes, names, scheme prefixes and percent escapes,
// both well formed and broken. A few are pure noise, a lone empty mark,
// or are cut short by an empty mark.
//
// Every hundred input words the handshake pressure moves to the next
// phase: no idling, sender idle, receiver stalling, then both.

module tb_top;
    import srpc_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1650;
    localparam int unsigned HANG_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Flag state of one rule checker. The NUL/backslash flag and the dot
    // flag hold the reason they stand for, or RSN_NONE.
    typedef struct packed {
        logic [1:0] seen;
        logic       lead_slash;
        logic       drive_mark;
        t_scheme    scheme;
        t_reason    first_bad;
        t_seg       seg;
        t_reason    dot_seg;
    } rules_t;

    localparam rules_t RULES_CLEAR = '{seen: 2'd0, lead_slash: 1'b0, drive_mark: 1'b0,
                                       scheme: SCH_NONE, first_bad: RSN_NONE,
                                       seg: SEG_EMPTY, dot_seg: RSN_NONE};

    // One queued input word and the handshake pressure of its phase.
    typedef struct {
        t_in_word    word;
        int unsigned gap_pct;
        int unsigned stall_pct;
    } stim_t;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_data;

    stim_t       bytes_to_send[$];
    t_out_word   verdicts_due[$];
    stim_t       head;
    int unsigned total_words;
    int unsigned words_taken = 0;
    int unsigned stall_pct   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned errors      = 0;
    logic        in_took     = 1'b0;

    // State of the verdict predictor.
    rules_t      raw_rules;
    rules_t      dec_rules;
    logic [7:0]  win_a;
    logic [7:0]  win_b;
    int unsigned win_count;
    logic        escape_seen;

    safe_relative_path_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Verdict predictor
    // ---------------------------------------------------------------

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_scheme_byte(input logic [7:0] b);
        return is_letter(b) || (b >= "0" && b <= "9") || b == CHR_PLUS ||
               b == CHR_MINUS || b == CHR_DOT;
    endfunction

    // Returns the digit value, or -1 when the byte is not a hex digit.
    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    // Only the first segment that is exactly "." or ".." is remembered.
    function automatic rules_t close_segment(input rules_t s);
        rules_t n;
        n = s;
        if (s.dot_seg == RSN_NONE) begin
            if (s.seg == SEG_DOT) begin
                n.dot_seg = RSN_DOT;
            end else if (s.seg == SEG_DOTDOT) begin
                n.dot_seg = RSN_DOTDOT;
            end
        end
        return n;
    endfunction

    function automatic rules_t rules_feed(input rules_t s, input logic [7:0] b);
        rules_t n;
        n = s;
        if (s.seen == 2'd0) begin
            n.lead_slash = (b == CHR_SLASH);
            n.scheme     = is_letter(b) ? SCH_CAND : SCH_NONE;
        end else if (s.scheme == SCH_CAND) begin
            // A colon right after a single letter is a drive as well as a scheme.
            if (b == CHR_COLON) begin
                n.scheme = SCH_FOUND;
                if (s.seen == 2'd1) begin
                    n.drive_mark = 1'b1;
                end
            end else if (!is_scheme_byte(b)) begin
                n.scheme = SCH_NONE;
            end
        end
        if (s.first_bad == RSN_NONE) begin
            if (b == CHR_NUL) begin
                n.first_bad = RSN_NUL;
            end else if (b == CHR_BSLASH) begin
                n.first_bad = RSN_BSLASH;
            end
        end
        if (b == CHR_SLASH) begin
            n     = close_segment(n);
            n.seg = SEG_EMPTY;
        end else if (b == CHR_DOT) begin
            case (s.seg)
                SEG_EMPTY: n.seg = SEG_DOT;
                SEG_DOT:   n.seg = SEG_DOTDOT;
                default:   n.seg = SEG_OTHER;
            endcase
        end else begin
            n.seg = SEG_OTHER;
        end
        if (s.seen != 2'd2) begin
            n.seen = s.seen + 2'd1;
        end
        return n;
    endfunction

    function automatic t_reason rules_verdict(input rules_t s);
        rules_t f;
        f = close_segment(s);
        if (f.seen == 2'd0) return RSN_EMPTY;
        if (f.lead_slash) return RSN_ABSOLUTE;
        if (f.drive_mark) return RSN_DRIVE;
        if (f.scheme == SCH_FOUND) return RSN_SCHEME;
        if (f.first_bad != RSN_NONE) return f.first_bad;
        return f.dot_seg;
    endfunction

    task automatic clear_predictor();
        raw_rules   = RULES_CLEAR;
        dec_rules   = RULES_CLEAR;
        win_a       = 8'h00;
        win_b       = 8'h00;
        win_count   = 0;
        escape_seen = 1'b0;
    endtask

    // Runs one accepted input word through the predictor and queues the
    // verdict that it causes, if any.
    task automatic predict_word(input t_in_word w);
        int         hi;
        int         lo;
        logic [7:0] decoded;
        t_reason    why;
        t_out_word  verdict;
        if (w.path_empty) begin
            clear_predictor();
            verdict.path_safe      = 1'b0;
            verdict.fail_reason    = RSN_EMPTY;
            verdict.failed_decoded = 1'b0;
            verdicts_due.push_back(verdict);
            return;
        end
        raw_rules = rules_feed(raw_rules, w.path_byte);
        // The window holds up to two bytes; a third one either completes an
        // escape with them or pushes the oldest byte out undecoded.
        if (win_count == 2) begin
            hi = hex_digit(win_b);
            lo = hex_digit(w.path_byte);
            if (win_a == CHR_PCT && hi >= 0 && lo >= 0) begin
                decoded     = 8'(hi * 16 + lo);
                dec_rules   = rules_feed(dec_rules, decoded);
                escape_seen = 1'b1;
                win_count   = 0;
            end else begin
                dec_rules = rules_feed(dec_rules, win_a);
                win_a     = win_b;
                win_b     = w.path_byte;
            end
        end else if (win_count == 1) begin
            win_b     = w.path_byte;
            win_count = 2;
        end else begin
            win_a     = w.path_byte;
            win_count = 1;
        end
        if (!w.is_last) return;
        if (win_count >= 1) dec_rules = rules_feed(dec_rules, win_a);
        if (win_count == 2) dec_rules = rules_feed(dec_rules, win_b);
        // The decoded form is judged only if the raw form passed and at
        // least one escape was decoded.
        why = rules_verdict(raw_rules);
        verdict.failed_decoded = 1'b0;
        if (why == RSN_NONE && escape_seen) begin
            why = rules_verdict(dec_rules);
            verdict.failed_decoded = (why != RSN_NONE);
        end
        verdict.path_safe   = (why == RSN_NONE);
        verdict.fail_reason = why;
        verdicts_due.push_back(verdict);
        clear_predictor();
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // The handshake phase follows the position of the word in the queue.
    task automatic queue_word(input logic [7:0] b, input logic last, input logic empty);
        stim_t s;
        s.word.path_byte  = b;
        s.word.is_last    = last;
        s.word.path_empty = empty;
        case ((bytes_to_send.size() / 100) % 4)
            0: begin
                s.gap_pct   = 0;
                s.stall_pct = 0;
            end
            1: begin
                s.gap_pct   = 64;
                s.stall_pct = 0;
            end
            2: begin
                s.gap_pct   = 0;
                s.stall_pct = 64;
            end
            default: begin
                s.gap_pct   = 14;
                s.stall_pct = 14;
            end
        endcase
        bytes_to_send.push_back(s);
    endtask

    task automatic queue_text(input string s, input logic close_path);
        int i;
        for (i = 0; i < s.len(); i++) begin
            queue_word(s[i], close_path && (i == s.len() - 1), 1'b0);
        end
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = ($urandom_range(1) != 0) ? "A" : "a";
        return 8'(base + $urandom_range(25));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        base = ($urandom_range(1) != 0) ? "A" : "a";
        if (v < 4'd10) return 8'("0" + v);
        return 8'(base + v - 8'd10);
    endfunction

    // Bytes that matter to the rules when they appear only after decoding.
    function automatic logic [7:0] risky_byte();
        case ($urandom_range(5))
            0:       return CHR_DOT;
            1:       return CHR_SLASH;
            2:       return CHR_BSLASH;
            3:       return CHR_NUL;
            4:       return CHR_COLON;
            default: return CHR_PCT;
        endcase
    endfunction

    task automatic push_escape(ref logic [7:0] body[$], input logic [7:0] v);
        body.push_back(CHR_PCT);
        body.push_back(hex_char(v[7:4]));
        body.push_back(hex_char(v[3:0]));
    endtask

    task automatic queue_random_path();
        logic [7:0]  body[$];
        logic [7:0]  tail;
        int unsigned pieces;
        int unsigned n;
        int unsigned k;
        int          i;
        if ($urandom_range(32) == 0) begin
            queue_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            return;
        end
        if ($urandom_range(19) == 0) begin
            // Pure noise.
            n = $urandom_range(1, 12);
            repeat (n) body.push_back(8'($urandom_range(255)));
        end else begin
            pieces = ($urandom_range(19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
            for (k = 0; k < pieces; k++) begin
                case ($urandom_range(12))
                    0: body.push_back(CHR_DOT);
                    1: begin
                        body.push_back(CHR_DOT);
                        body.push_back(CHR_DOT);
                    end
                    2: body.push_back(CHR_SLASH);
                    3: begin
                        n = $urandom_range(1, 4);
                        repeat (n) body.push_back(random_letter());
                    end
                    4: push_escape(body, risky_byte());
                    5: body.push_back(CHR_COLON);
                    6: begin
                        // Letter, some scheme characters, then a colon.
                        body.push_back(random_letter());
                        n = $urandom_range(0, 3);
                        repeat (n) body.push_back(($urandom_range(1) != 0) ?
                                                  random_letter() : CHR_PLUS);
                        body.push_back(CHR_COLON);
                    end
                    7: body.push_back(8'($urandom_range(255)));
                    8: body.push_back(($urandom_range(1) != 0) ? CHR_BSLASH : CHR_NUL);
                    9: begin
                        // Mostly a broken escape: a percent sign, maybe one hex digit, maybe a letter.
                        body.push_back(CHR_PCT);
                        if ($urandom_range(1) != 0) begin
                            body.push_back(hex_char(4'($urandom_range(15))));
                        end
                        if ($urandom_range(1) != 0) body.push_back(random_letter());
                    end
                    10: begin
                        // Double encoding decodes only once.
                        push_escape(body, CHR_PCT);
                        body.push_back(hex_char(4'($urandom_range(15))));
                        body.push_back(hex_char(4'($urandom_range(15))));
                    end
                    11: begin
                        tail = ($urandom_range(1) != 0) ? CHR_MINUS : CHR_PLUS;
                        body.push_back(($urandom_range(1) != 0) ? tail :
                                       8'("0" + $urandom_range(9)));
                    end
                    default: push_escape(body, 8'($urandom_range(255)));
                endcase
            end
        end
        if ($urandom_range(24) == 0) begin
            // The path is cut short by an empty mark.
            for (i = 0; i < body.size(); i++) queue_word(body[i], 1'b0, 1'b0);
            queue_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
            for (i = 0; i < body.size(); i++) begin
                queue_word(body[i], i == body.size() - 1, 1'b0);
            end
        end
    endtask

    initial begin
        int unsigned directed_words;
        clear_predictor();

        // Directed paths, one per rule and special case.
        queue_word(8'hFF, 1'b1, 1'b1);   // empty path that also carries a last mark
        queue_text("/", 1'b1);
        queue_text("c:", 1'b1);
        queue_text("z+:", 1'b1);
        queue_word(CHR_NUL, 1'b1, 1'b0);
        queue_text("\\", 1'b1);
        queue_text(".", 1'b1);
        queue_text("..", 1'b1);
        queue_text("%2e", 1'b1);         // safe raw, a dot segment once decoded
        queue_text("ab", 1'b0);
        queue_word(8'h00, 1'b0, 1'b1);   // empty mark drops the unfinished path
        queue_text("x%", 1'b1);          // window tail passes through undecoded
        queue_word(8'hFF, 1'b1, 1'b0);
        directed_words = bytes_to_send.size();

        while (bytes_to_send.size() < directed_words + RANDOM_WORDS) begin
            queue_random_path();
        end
        total_words = bytes_to_send.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < total_words || verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("safe_relative_path_checker test passed");
        end else begin
            $display("safe_relative_path_checker test failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: changes inputs at the falling edge only. A new word goes out
    // once the previous one was taken at the last rising edge.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_took)) begin
            if (bytes_to_send.size() != 0 &&
                $urandom_range(99) >= bytes_to_send[0].gap_pct) begin
                head = bytes_to_send.pop_front();
                in_valid  <= 1'b1;
                in_data   <= head.word;
                stall_pct <= head.stall_pct;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge, predicts on
    // accepted input words and checks accepted output words. The watchdog
    // ends the run when no word moves for too long.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t ns: verdict with none due, expected nothing, actual safe=%0b reason=%0d decoded=%0b",
                             $time, o_out_data.path_safe, o_out_data.fail_reason,
                             o_out_data.failed_decoded);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_out_data !== want) begin
                        $display("%0t ns: verdict mismatch, expected safe=%0b reason=%0d decoded=%0b, actual safe=%0b reason=%0d decoded=%0b",
                                 $time, want.path_safe, want.fail_reason, want.failed_decoded,
                                 o_out_data.path_safe, o_out_data.fail_reason,
                                 o_out_data.failed_decoded);
                        errors++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                predict_word(in_data);
                words_taken <= words_taken + 1;
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= HANG_LIMIT) begin
                $display("safe_relative_path_checker test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
        in_took <= i_rst_n && in_valid && o_in_ready;
    end

endmodule

/* sim.f */
src/srpc_pkg.sv
src/srpc_in_reg.sv
src/srpc_core.sv
src/safe_relative_path_checker.sv
sim/tb_top.sv
